FILE: rtl/hsv_to_rgb_converter_core_macros.svh
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter_core_macros
// assertion macros used by the converter core
// ---------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_CORE_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_CORE_MACROS_SVH

// checked only out of reset
`define HSV2RGB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define HSV2RGB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/hsv2rgb_pkg.sv
// ---------------------------------------------------------------------------
// hsv2rgb_pkg
// widths, constants, types and helpers of the hsv to rgb converter
// ---------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam int HUE_W  = 13;
    localparam int PCT_IW = 15;
    localparam int PCT_W  = 14;
    localparam int REM_W  = 10;
    localparam int LVL_W  = 24;
    localparam int CHAN_W = 16;
    localparam int PROD_W = PCT_W + LVL_W;
    localparam int PSH    = 8;
    localparam int X_W    = PROD_W - PSH;
    localparam int Q_W    = CHAN_W + 1;
    localparam int M_W    = 23;
    localparam int RECIP_SHIFT = 36;

    localparam logic [HUE_W-1:0]  HUE_FULL   = 13'd5760;
    localparam logic [REM_W-1:0]  HUE_SECTOR = 10'd960;
    localparam logic [PCT_W-1:0]  PCT_FULL   = 14'd12800;
    localparam logic [LVL_W-1:0]  LEVEL_ONE  = 24'd12288000;
    localparam logic [PROD_W-1:0] ROUND_HALF = 38'd1200000;
    localparam logic [PCT_W-1:0]  DIV_K      = 14'd9375;
    localparam logic [M_W-1:0]    RECIP_M    = 23'd7330077;
    localparam logic [CHAN_W-1:0] CHAN_MAX   = 16'hffff;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    typedef struct packed {
        logic [PCT_W-1:0] val;
        logic [LVL_W-1:0] lvl_red;
        logic [LVL_W-1:0] lvl_green;
        logic [LVL_W-1:0] lvl_blue;
    } t_levels;

    function automatic logic [PCT_W-1:0] clamp_pct(input logic signed [PCT_IW-1:0] raw);
        logic [PCT_W-1:0] mag;
        mag = raw[PCT_W-1:0];
        if (raw[PCT_IW-1]) begin
            return '0;
        end
        return (mag > PCT_FULL) ? PCT_FULL : mag;
    endfunction

endpackage

FILE: rtl/hsv_to_rgb_converter_core.sv
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// six-sector hsv to rgb conversion, five register stages
//
//   channel  direction  handshake           payload
//   in       to core    i_valid / o_stall   i_hue, i_saturation, i_brightness
//   out      from core  o_valid / i_stall   o_red, o_green, o_blue
//
// one item per cycle while the output is not stalled
// items pass through the per-channel multiply and reciprocal divide stages
// synchronous reset clears only the valid pipeline
// a stalled output freezes every stage, so o_stall follows it at once
// ---------------------------------------------------------------------------
`include "hsv_to_rgb_converter_core_macros.svh"

module hsv_to_rgb_converter_core import hsv2rgb_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [HUE_W-1:0]         i_hue,
    input  logic signed [PCT_IW-1:0] i_saturation,
    input  logic signed [PCT_IW-1:0] i_brightness,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [CHAN_W-1:0]        o_red,
    output logic [CHAN_W-1:0]        o_green,
    output logic [CHAN_W-1:0]        o_blue
);

    localparam int STAGES = 5;

    logic              w_adv;
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    t_levels           w_lvl;

    assign w_adv   = !(r_vld[STAGES-1] && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_vld[STAGES-1];

    always_comb begin
        n_vld = r_vld;
        if (w_adv) begin
            n_vld = {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    hsv2rgb_front u_front (
        .i_clk        (i_clk),
        .i_en         (w_adv),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_lvl        (w_lvl)
    );

    hsv2rgb_lane u_lane_red (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_val  (w_lvl.val),
        .i_lvl  (w_lvl.lvl_red),
        .o_chan (o_red)
    );

    hsv2rgb_lane u_lane_green (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_val  (w_lvl.val),
        .i_lvl  (w_lvl.lvl_green),
        .o_chan (o_green)
    );

    hsv2rgb_lane u_lane_blue (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_val  (w_lvl.val),
        .i_lvl  (w_lvl.lvl_blue),
        .o_chan (o_blue)
    );

    `HSV2RGB_ASSERT_ALWAYS(a_rst_clears, !i_rst_n |=> !o_valid, "valid set right after reset")
    `HSV2RGB_ASSERT(a_stall_freezes, o_valid && i_stall |=> $stable(r_vld), "pipe moved while stalled")
    `HSV2RGB_ASSERT(a_no_drop, w_adv && r_vld[STAGES-2] |=> o_valid, "item lost in last stage")

endmodule

FILE: rtl/hsv2rgb_front.sv
// ---------------------------------------------------------------------------
// hsv2rgb_front
// two stages: clamp and sector split, then per-channel level selection
// ---------------------------------------------------------------------------
module hsv2rgb_front import hsv2rgb_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [HUE_W-1:0]         i_hue,
    input  logic signed [PCT_IW-1:0] i_saturation,
    input  logic signed [PCT_IW-1:0] i_brightness,
    output t_levels                  o_lvl
);

    logic [HUE_W-1:0] n_hue;
    logic [HUE_W-1:0] n_base;
    t_sector          n_sec;
    logic [REM_W-1:0] n_rem;

    t_sector          r_sec;
    logic [REM_W-1:0] r_rem;
    logic [PCT_W-1:0] r_sat;
    logic [PCT_W-1:0] r_val;

    logic [LVL_W-1:0] w_sp;
    logic [LVL_W-1:0] w_sq;
    logic [LVL_W-1:0] w_st;
    logic [LVL_W-1:0] w_lp;
    logic [LVL_W-1:0] w_lq;
    logic [LVL_W-1:0] w_lt;
    logic [REM_W-1:0] w_crem;
    t_levels          n_lvl;
    t_levels          r_lvl;

    // stage 1: hue wrap, sector split, saturation and value clamp
    always_comb begin
        n_hue = (i_hue >= HUE_FULL) ? '0 : i_hue;
        if (n_hue < HUE_W'(960)) begin
            n_sec  = SEC_0;
            n_base = HUE_W'(0);
        end else if (n_hue < HUE_W'(1920)) begin
            n_sec  = SEC_1;
            n_base = HUE_W'(960);
        end else if (n_hue < HUE_W'(2880)) begin
            n_sec  = SEC_2;
            n_base = HUE_W'(1920);
        end else if (n_hue < HUE_W'(3840)) begin
            n_sec  = SEC_3;
            n_base = HUE_W'(2880);
        end else if (n_hue < HUE_W'(4800)) begin
            n_sec  = SEC_4;
            n_base = HUE_W'(3840);
        end else begin
            n_sec  = SEC_5;
            n_base = HUE_W'(4800);
        end
        n_rem = REM_W'(n_hue - n_base);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sec <= n_sec;
            r_rem <= n_rem;
            r_sat <= clamp_pct(i_saturation);
            r_val <= clamp_pct(i_brightness);
        end
    end

    // stage 2: p, q, t levels and sector routing
    assign w_crem = HUE_SECTOR - r_rem;
    assign w_sp   = LVL_W'(r_sat) * LVL_W'(HUE_SECTOR);
    assign w_sq   = LVL_W'(r_sat) * LVL_W'(r_rem);
    assign w_st   = LVL_W'(r_sat) * LVL_W'(w_crem);
    assign w_lp   = LEVEL_ONE - w_sp;
    assign w_lq   = LEVEL_ONE - w_sq;
    assign w_lt   = LEVEL_ONE - w_st;

    always_comb begin
        n_lvl.val = r_val;
        case (r_sec)
            SEC_0: begin
                n_lvl.lvl_red   = LEVEL_ONE;
                n_lvl.lvl_green = w_lt;
                n_lvl.lvl_blue  = w_lp;
            end
            SEC_1: begin
                n_lvl.lvl_red   = w_lq;
                n_lvl.lvl_green = LEVEL_ONE;
                n_lvl.lvl_blue  = w_lp;
            end
            SEC_2: begin
                n_lvl.lvl_red   = w_lp;
                n_lvl.lvl_green = LEVEL_ONE;
                n_lvl.lvl_blue  = w_lt;
            end
            SEC_3: begin
                n_lvl.lvl_red   = w_lp;
                n_lvl.lvl_green = w_lq;
                n_lvl.lvl_blue  = LEVEL_ONE;
            end
            SEC_4: begin
                n_lvl.lvl_red   = w_lt;
                n_lvl.lvl_green = w_lp;
                n_lvl.lvl_blue  = LEVEL_ONE;
            end
            default: begin
                n_lvl.lvl_red   = LEVEL_ONE;
                n_lvl.lvl_green = w_lp;
                n_lvl.lvl_blue  = w_lq;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lvl <= n_lvl;
        end
    end

    assign o_lvl = r_lvl;

endmodule

FILE: rtl/hsv2rgb_lane.sv
// ---------------------------------------------------------------------------
// hsv2rgb_lane
// one channel: scale by value, divide by 2400000 with rounding, saturate
// ---------------------------------------------------------------------------
module hsv2rgb_lane import hsv2rgb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [PCT_W-1:0]  i_val,
    input  logic [LVL_W-1:0]  i_lvl,
    output logic [CHAN_W-1:0] o_chan
);

    localparam int MX_W = X_W + M_W;

    logic [PROD_W-1:0] n_prod;
    logic [PROD_W-1:0] r_prod;
    logic [X_W-1:0]    w_x;
    logic [MX_W-1:0]   w_mx;
    logic [X_W-1:0]    r_x;
    logic [Q_W-1:0]    r_qe;
    logic [X_W-1:0]    w_rem;
    logic [Q_W-1:0]    w_q;
    logic [CHAN_W-1:0] n_chan;
    logic [CHAN_W-1:0] r_chan;

    // stage 3: value times level plus half divisor
    assign n_prod = PROD_W'(i_val) * PROD_W'(i_lvl) + ROUND_HALF;

    // stage 4: quotient estimate by reciprocal, low by at most one
    assign w_x  = r_prod[PROD_W-1:PSH];
    assign w_mx = MX_W'(w_x) * MX_W'(RECIP_M);

    // stage 5: correction and saturation
    assign w_rem  = r_x - X_W'(r_qe) * X_W'(DIV_K);
    assign w_q    = (w_rem >= X_W'(DIV_K)) ? Q_W'(r_qe + Q_W'(1)) : r_qe;
    assign n_chan = w_q[Q_W-1] ? CHAN_MAX : w_q[CHAN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_x    <= w_x;
            r_qe   <= w_mx[RECIP_SHIFT +: Q_W];
            r_chan <= n_chan;
        end
    end

    assign o_chan = r_chan;

endmodule

FILE: tb/sv/tb_hsv_to_rgb_converter_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_hsv_to_rgb_converter_core
// self-checking testbench of the hsv to rgb conversion pipeline
//
// a short table of hand-picked pixels (primaries, hue wrap, gray, clamping
// of saturation and value) goes first, then random pixels mostly in the
// legal ranges. each output item is compared per channel against its table
// colour or a local integer model of the six-sector conversion. the sender
// idles and the receiver stalls at random, in phases of different pressure.
// ---------------------------------------------------------------------------
module tb_hsv_to_rgb_converter_core;
    import hsv2rgb_pkg::*;

    localparam int ITEM_TOTAL   = 1550;
    localparam int DIRECTED_CNT = 22;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam longint unsigned LEVEL_DEN = 64'd157286400000;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [HUE_W-1:0]         hue;
        logic signed [PCT_IW-1:0] sat;
        logic signed [PCT_IW-1:0] bri;
        logic                     known;
        t_rgb                     rgb;
    } t_pixel;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_valid      = 1'b0;
    logic                     i_stall      = 1'b0;
    logic [HUE_W-1:0]         i_hue        = '0;
    logic signed [PCT_IW-1:0] i_saturation = '0;
    logic signed [PCT_IW-1:0] i_brightness = '0;
    logic                     o_stall;
    logic                     o_valid;
    logic [CHAN_W-1:0]        o_red;
    logic [CHAN_W-1:0]        o_green;
    logic [CHAN_W-1:0]        o_blue;

    t_pixel directed_rows [DIRECTED_CNT];
    t_pixel pixel_queue [$];
    t_rgb   rgb_expected [$];
    t_pixel cur_pixel   = '0;
    int     loaded      = 0;
    int     items_in    = 0;
    int     items_out   = 0;
    int     errors      = 0;
    int     idle_cycles = 0;
    int     sender_pct;
    int     stall_pct;

    hsv_to_rgb_converter_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint unsigned limit_percent(input logic signed [PCT_IW-1:0] raw);
        longint x;
        x = raw;
        if (x < 0) begin
            return 0;
        end
        return (x > PCT_FULL) ? PCT_FULL : x;
    endfunction

    function automatic logic [CHAN_W-1:0] level_to_chan(input longint unsigned num);
        longint unsigned q;
        q = (num * 64'd65536 + LEVEL_DEN / 2) / LEVEL_DEN;
        return (q > CHAN_MAX) ? CHAN_MAX : q[CHAN_W-1:0];
    endfunction

    function automatic t_rgb hsv_to_rgb_expected(input logic [HUE_W-1:0] hue,
                                                 input logic signed [PCT_IW-1:0] sat,
                                                 input logic signed [PCT_IW-1:0] bri);
        longint unsigned h, s, v, frac;
        logic [CHAN_W-1:0] cv, cp, cq, ct;
        t_sector sector;
        t_rgb res;
        h = hue;
        if (h >= HUE_FULL) begin
            h = 0;
        end
        s = limit_percent(sat);
        v = limit_percent(bri);
        sector = t_sector'(h / HUE_SECTOR);
        frac = h % HUE_SECTOR;
        cv = level_to_chan(v * LEVEL_ONE);
        cp = level_to_chan(v * (LEVEL_ONE - HUE_SECTOR * s));
        cq = level_to_chan(v * (LEVEL_ONE - s * frac));
        ct = level_to_chan(v * (LEVEL_ONE - s * (HUE_SECTOR - frac)));
        case (sector)
            SEC_0:   res = '{cv, ct, cp};
            SEC_1:   res = '{cq, cv, cp};
            SEC_2:   res = '{cp, cv, ct};
            SEC_3:   res = '{cp, cq, cv};
            SEC_4:   res = '{ct, cp, cv};
            default: res = '{cv, cp, cq};
        endcase
        return res;
    endfunction

    function automatic logic [PCT_IW-1:0] rand_percent();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            return PCT_IW'($urandom_range(0, 12800));
        end else if (roll < 85) begin
            return ($urandom_range(0, 1) != 0) ? PCT_IW'(PCT_FULL) : '0;
        end
        return PCT_IW'($urandom_range(0, 32767));
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel px;
        px = '0;
        if ($urandom_range(0, 99) < 85) begin
            px.hue = HUE_W'($urandom_range(0, 5759));
        end else begin
            px.hue = HUE_W'($urandom_range(0, 8191));
        end
        px.sat = rand_percent();
        px.bri = rand_percent();
        return px;
    endfunction

    task automatic check_chan(input string name, input logic [CHAN_W-1:0] want,
                              input logic [CHAN_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
        end
    endtask

    // pressure phases over the item stream
    always_comb begin
        case (loaded * 5 / ITEM_TOTAL)
            1:       begin sender_pct = 63; stall_pct = 0;  end
            2:       begin sender_pct = 0;  stall_pct = 63; end
            3:       begin sender_pct = 21; stall_pct = 21; end
            default: begin sender_pct = 0;  stall_pct = 0;  end
        endcase
    end

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (pixel_queue.size() > 0 && $urandom_range(0, 99) >= sender_pct) begin
                i_valid      <= 1'b1;
                i_hue        <= pixel_queue[0].hue;
                i_saturation <= pixel_queue[0].sat;
                i_brightness <= pixel_queue[0].bri;
                cur_pixel    <= pixel_queue.pop_front();
                loaded       <= loaded + 1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // scoreboard and watchdog
    always @(posedge i_clk) begin
        t_rgb want;
        logic took_in, took_out;
        took_out = i_rst_n && o_valid && !i_stall;
        took_in  = i_rst_n && i_valid && !o_stall;
        if (took_out) begin
            items_out <= items_out + 1;
            if (rgb_expected.size() == 0) begin
                errors++;
                $display("%0t unexpected item: actual %h %h %h", $time, o_red, o_green, o_blue);
            end else begin
                want = rgb_expected.pop_front();
                check_chan("red", want.red, o_red);
                check_chan("green", want.green, o_green);
                check_chan("blue", want.blue, o_blue);
            end
        end
        if (took_in) begin
            items_in <= items_in + 1;
            if (cur_pixel.known) begin
                rgb_expected.push_back(cur_pixel.rgb);
            end else begin
                rgb_expected.push_back(hsv_to_rgb_expected(i_hue, i_saturation, i_brightness));
            end
        end
        if (took_in || took_out || (items_in == ITEM_TOTAL && items_out == items_in)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        directed_rows = '{
            '{13'd0,    15'sd12800, 15'sd12800, 1'b1, '{16'hffff, 16'h0000, 16'h0000}},
            '{13'd960,  15'sd12800, 15'sd12800, 1'b1, '{16'hffff, 16'hffff, 16'h0000}},
            '{13'd1920, 15'sd12800, 15'sd12800, 1'b1, '{16'h0000, 16'hffff, 16'h0000}},
            '{13'd2880, 15'sd12800, 15'sd12800, 1'b1, '{16'h0000, 16'hffff, 16'hffff}},
            '{13'd3840, 15'sd12800, 15'sd12800, 1'b1, '{16'h0000, 16'h0000, 16'hffff}},
            '{13'd4800, 15'sd12800, 15'sd12800, 1'b1, '{16'hffff, 16'h0000, 16'hffff}},
            '{13'd5760, 15'sd12800, 15'sd12800, 1'b1, '{16'hffff, 16'h0000, 16'h0000}},
            '{13'd8191, 15'sd12800, 15'sd12800, 1'b1, '{16'hffff, 16'h0000, 16'h0000}},
            '{13'd0,    15'sd0,     15'sd12800, 1'b1, '{16'hffff, 16'hffff, 16'hffff}},
            '{13'd1234, 15'sd0,     15'sd0,     1'b1, '{16'h0000, 16'h0000, 16'h0000}},
            '{13'd3000, 15'sd12800, 15'h7fff,   1'b1, '{16'h0000, 16'h0000, 16'h0000}},
            '{13'd3000, 15'h4000,   15'sd12800, 1'b1, '{16'hffff, 16'hffff, 16'hffff}},
            '{13'd2000, 15'h7fff,   15'sd6400,  1'b1, '{16'h8000, 16'h8000, 16'h8000}},
            '{13'd8191, 15'h4000,   15'h4000,   1'b1, '{16'h0000, 16'h0000, 16'h0000}},
            '{13'd5000, 15'sd16383, 15'sd16383, 1'b0, '0},
            '{13'd959,  15'sd12800, 15'sd12800, 1'b0, '0},
            '{13'd5759, 15'sd12800, 15'sd12800, 1'b0, '0},
            '{13'd480,  15'sd6400,  15'sd6400,  1'b0, '0},
            '{13'd1,    15'sd1,     15'sd1,     1'b0, '0},
            '{13'd4321, 15'sd12801, 15'sd12799, 1'b0, '0},
            '{13'd2500, 15'sd9000,  15'sd12801, 1'b0, '0},
            '{13'd6000, 15'sd3000,  15'sd7000,  1'b0, '0}
        };
        foreach (directed_rows[k]) begin
            pixel_queue.push_back(directed_rows[k]);
        end
        while (pixel_queue.size() < ITEM_TOTAL) begin
            pixel_queue.push_back(rand_pixel());
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_in < ITEM_TOTAL || items_out < items_in) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && rgb_expected.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_front.sv
rtl/hsv2rgb_lane.sv
rtl/hsv_to_rgb_converter_core.sv
tb/sv/tb_hsv_to_rgb_converter_core.sv
